// ----- hdl/csmkt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package csmkt_pkg;

  localparam int CELL_SIZE    = 8;
  localparam int MAX_GRID_DIM = 256;
  localparam int BIN_COUNT    = CELL_SIZE * CELL_SIZE;

  localparam int BIN_W   = $clog2(BIN_COUNT);
  localparam int CH_W    = $clog2(BIN_COUNT + 1);
  localparam int CS_W    = (CELL_SIZE > 2) ? $clog2(CELL_SIZE) : 1;
  localparam int GRID_W  = $clog2(MAX_GRID_DIM);
  localparam int DIM_W   = 9;
  localparam int FRAC_W  = 3;
  localparam int SCORE_W = 16;
  localparam int LOGIT_W = 8;
  localparam int POINT_W = 11;
  localparam int CFG_W   = 16;
  localparam int REG_IDX_W = 2;

  // exp table: index m holds exp(-m/128) in Q1.16
  localparam int ROM_LEN = 1536;
  localparam int ROM_AW  = $clog2(ROM_LEN);
  localparam int M_W     = LOGIT_W + 7;
  localparam int EXP_W   = 17;
  localparam int SUM_W   = 24;

  // quotient bits and two steps per divider cycle
  localparam int Q_W        = EXP_W + 1;
  localparam int PRE_SHIFT  = Q_W - SCORE_W;
  localparam int DIV_CYCLES = Q_W / 2;
  localparam int DCNT_W     = $clog2(DIV_CYCLES);

  localparam logic [63:0] EXP_STEP_Q32 = 64'd4261543595;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GRID_WIDTH      = 2'd0,
    REG_GRID_HEIGHT     = 2'd1,
    REG_FRAC_BITS       = 2'd2,
    REG_SCORE_THRESHOLD = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACCUM,
    S_READ,
    S_START,
    S_DIV,
    S_CHECK,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic in_load;
    logic accum;
    logic div_start;
    logic check;
    logic bin_adv;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic dustbin;
    logic div_done;
    logic hit;
    logic pend_valid;
    logic out_free;
    logic bin_last;
  } status_t;

  typedef logic [EXP_W-1:0] exp_rom_t [ROM_LEN];

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] e;
    logic [63:0] p;
    e = 64'd1 << 32;
    for (int m = 0; m < ROM_LEN; m++) begin
      rom[m] = EXP_W'((e + 64'd32768) >> 16);
      p = e * EXP_STEP_Q32;
      e = (p + 64'h8000_0000) >> 32;
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

`default_nettype wire

// ----- hdl/csmkt_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module csmkt_div import csmkt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [EXP_W-1:0] dividend,
  input  logic [SUM_W-1:0] divisor,
  output logic             done,
  output logic [Q_W-1:0]   quotient
);

  logic [SUM_W-1:0]  rem;
  logic [Q_W-1:0]    nbits;
  logic [DCNT_W-1:0] cnt;
  logic              busy;

  logic [SUM_W:0]   t1;
  logic [SUM_W:0]   t2;
  logic             ge1;
  logic             ge2;
  logic [SUM_W-1:0] r1;
  logic [SUM_W-1:0] r2;

  // two restoring steps per cycle; remainder stays below the divisor
  always_comb begin
    t1  = {rem, nbits[Q_W-1]};
    ge1 = t1 >= {1'b0, divisor};
    r1  = ge1 ? SUM_W'(t1 - {1'b0, divisor}) : SUM_W'(t1);
    t2  = {r1, nbits[Q_W-2]};
    ge2 = t2 >= {1'b0, divisor};
    r2  = ge2 ? SUM_W'(t2 - {1'b0, divisor}) : SUM_W'(t2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= DCNT_W'(DIV_CYCLES - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // numerator is dividend shifted up by the score fraction width
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= SUM_W'(dividend >> PRE_SHIFT);
      nbits    <= Q_W'(dividend) << SCORE_W;
      quotient <= '0;
    end else if (busy) begin
      rem      <= r2;
      nbits    <= nbits << 2;
      quotient <= {quotient[Q_W-3:0], ge1, ge2};
    end
  end

endmodule

`default_nettype wire

// ----- hdl/csmkt_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module csmkt_dp import csmkt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic signed [LOGIT_W-1:0] logit,
  input  logic                 frame_start,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [POINT_W-1:0]   point_x,
  output logic [POINT_W-1:0]   point_y,
  output logic [SCORE_W-1:0]   score,
  output logic                 cell_last
);

  logic [DIM_W-1:0]   grid_width;
  logic [DIM_W-1:0]   grid_height;
  logic [FRAC_W-1:0]  frac_bits;
  logic [SCORE_W-1:0] score_threshold;

  logic [EXP_W-1:0]  rom_q;
  logic              fs_q;
  logic [SUM_W-1:0]  exp_sum;
  logic [CH_W-1:0]   channel_count;
  logic [GRID_W-1:0] cell_col;
  logic [GRID_W-1:0] cell_row;

  logic [EXP_W-1:0]  exp_store [BIN_COUNT];
  logic [EXP_W-1:0]  rd_q;

  logic [BIN_W-1:0]  bin;
  logic [CS_W-1:0]   bin_col;
  logic [CS_W-1:0]   bin_row;

  logic               pend_valid;
  logic [POINT_W-1:0] pend_x;
  logic [POINT_W-1:0] pend_y;
  logic [SCORE_W-1:0] pend_s;

  logic               div_done;
  logic [Q_W-1:0]     quotient;

  logic [7:0]         logit_gap;
  logic [M_W-1:0]     m;
  logic [CH_W-1:0]    ch_eff;
  logic               dustbin;
  logic [SCORE_W-1:0] score_c;
  logic               hit;
  logic [POINT_W-1:0] x_c;
  logic [POINT_W-1:0] y_c;
  logic               out_free;
  logic               out_load;
  logic [DIM_W-1:0]   eff_w;
  logic [DIM_W-1:0]   eff_h;
  logic [DIM_W-1:0]   col_inc;
  logic [DIM_W-1:0]   row_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width      <= DIM_W'(80);
      grid_height     <= DIM_W'(60);
      frac_bits       <= FRAC_W'(4);
      score_threshold <= SCORE_W'(983);
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_GRID_WIDTH:      grid_width      <= cfg_data[DIM_W-1:0];
        REG_GRID_HEIGHT:     grid_height     <= cfg_data[DIM_W-1:0];
        REG_FRAC_BITS:       frac_bits       <= cfg_data[FRAC_W-1:0];
        REG_SCORE_THRESHOLD: score_threshold <= cfg_data[SCORE_W-1:0];
      endcase
    end
  end

  // table index: (127 - logit) scaled to steps of 1/128
  always_comb begin
    logit_gap = 8'(8'd127 - $unsigned(logit));
    m         = M_W'(logit_gap) << (~frac_bits);
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      rom_q <= (m < M_W'(ROM_LEN)) ? EXP_ROM[m[ROM_AW-1:0]] : '0;
      fs_q  <= frame_start;
    end
  end

  assign ch_eff  = fs_q ? '0 : channel_count;
  assign dustbin = ch_eff == CH_W'(BIN_COUNT);

  always_comb begin
    eff_w = (grid_width == '0) ? DIM_W'(1) :
            (grid_width > DIM_W'(MAX_GRID_DIM)) ? DIM_W'(MAX_GRID_DIM) : grid_width;
    eff_h = (grid_height == '0) ? DIM_W'(1) :
            (grid_height > DIM_W'(MAX_GRID_DIM)) ? DIM_W'(MAX_GRID_DIM) : grid_height;
    col_inc = DIM_W'(cell_col) + 1'b1;
    row_inc = DIM_W'(cell_row) + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_sum       <= '0;
      channel_count <= '0;
      cell_col      <= '0;
      cell_row      <= '0;
    end else if (cmd.accum) begin
      exp_sum       <= (fs_q ? '0 : exp_sum) + SUM_W'(rom_q);
      channel_count <= dustbin ? ch_eff : ch_eff + 1'b1;
      if (fs_q) begin
        cell_col <= '0;
        cell_row <= '0;
      end
    end else if (cmd.flush) begin
      exp_sum       <= '0;
      channel_count <= '0;
      // wrap at the clamped grid edge
      if (col_inc >= eff_w) begin
        cell_col <= '0;
        cell_row <= (row_inc >= eff_h) ? '0 : GRID_W'(row_inc);
      end else begin
        cell_col <= GRID_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accum && !dustbin) begin
      exp_store[ch_eff[BIN_W-1:0]] <= rom_q;
    end
    rd_q <= exp_store[bin];
  end

  always_ff @(posedge clk) begin
    if (cmd.accum) begin
      bin     <= '0;
      bin_col <= '0;
      bin_row <= '0;
    end else if (cmd.bin_adv) begin
      bin <= bin + 1'b1;
      if (bin_col == CS_W'(CELL_SIZE - 1)) begin
        bin_col <= '0;
        bin_row <= bin_row + 1'b1;
      end else begin
        bin_col <= bin_col + 1'b1;
      end
    end
  end

  csmkt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (rd_q),
    .divisor  (exp_sum),
    .done     (div_done),
    .quotient (quotient)
  );

  // zero sum scores zero; a quotient of one saturates
  always_comb begin
    if (exp_sum == '0) begin
      score_c = '0;
    end else if (quotient[Q_W-1:SCORE_W] != '0) begin
      score_c = '1;
    end else begin
      score_c = quotient[SCORE_W-1:0];
    end
    hit = score_c > score_threshold;
    x_c = POINT_W'(POINT_W'(cell_col) * POINT_W'(CELL_SIZE) + POINT_W'(bin_col));
    y_c = POINT_W'(POINT_W'(cell_row) * POINT_W'(CELL_SIZE) + POINT_W'(bin_row));
  end

  assign out_free = !out_valid || !out_stall;
  assign out_load = pend_valid && ((cmd.check && hit) || cmd.flush);

  // hold one kept point back so the last one of the cell can be marked
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.check && hit) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check && hit) begin
      pend_x <= x_c;
      pend_y <= y_c;
      pend_s <= score_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      point_x   <= pend_x;
      point_y   <= pend_y;
      score     <= pend_s;
      cell_last <= cmd.flush;
    end
  end

  always_comb begin
    status.dustbin    = dustbin;
    status.div_done   = div_done;
    status.hit        = hit;
    status.pend_valid = pend_valid;
    status.out_free   = out_free;
    status.bin_last   = bin == BIN_W'(BIN_COUNT - 1);
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("output word overwritten before it was taken");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> !pend_valid && channel_count == '0 && exp_sum == '0)
    else $error("cell state not cleared after flush");

  a_hit_pends: assert property (@(posedge clk) disable iff (rst)
    (cmd.check && hit) |=> pend_valid && pend_s > score_threshold)
    else $error("kept point not held for output");
`endif

endmodule

`default_nettype wire

// ----- hdl/csmkt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module csmkt_ctrl import csmkt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   push_blocked;

  assign push_blocked = status.pend_valid && !status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_ACCUM;
      S_ACCUM: state_next = status.dustbin ? S_READ : S_IDLE;
      S_READ:  state_next = S_START;
      S_START: state_next = S_DIV;
      S_DIV:   if (status.div_done) state_next = S_CHECK;
      S_CHECK: begin
        if (!(status.hit && push_blocked)) begin
          state_next = status.bin_last ? S_FLUSH : S_READ;
        end
      end
      S_FLUSH: if (!push_blocked) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_stall     = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.in_load = in_valid;
      end
      S_ACCUM: cmd.accum     = 1'b1;
      S_READ:  cmd           = '0;
      S_START: cmd.div_start = 1'b1;
      S_DIV:   cmd           = '0;
      S_CHECK: begin
        cmd.check   = !(status.hit && push_blocked);
        cmd.bin_adv = !(status.hit && push_blocked) && !status.bin_last;
      end
      S_FLUSH: cmd.flush = !push_blocked;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/cell_softmax_keypoint_threshold_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            payload
// in        sink       in_valid/in_stall    logit, frame_start
// out       source     out_valid/out_stall  point_x, point_y, score, cell_last
// cfg       sink       cfg_write            cfg_index, cfg_data
//
// Each logit is accepted, then its table lookup result is summed and stored.
// The dustbin logit starts the cell pass: per bin a store read, a divider load, the
// two-bit-per-cycle divider and a compare, then a flush at the end of the cell; the
// pass takes longer while the output register is stalled with a word pending.
// Reset (rst, synchronous) clears counters, sum, pending and output valid flags.
// The input is stalled from acceptance until the logit is summed, and after the dustbin until the cell pass is done.

module cell_softmax_keypoint_threshold_unit import csmkt_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [REG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [LOGIT_W-1:0] logit,
  input  logic                      frame_start,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [POINT_W-1:0]        point_x,
  output logic [POINT_W-1:0]        point_y,
  output logic [SCORE_W-1:0]        score,
  output logic                      cell_last
);

  cmd_t    cmd;
  status_t status;

  csmkt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  csmkt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .logit       (logit),
    .frame_start (frame_start),
    .cmd         (cmd),
    .status      (status),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .point_x     (point_x),
    .point_y     (point_y),
    .score       (score),
    .cell_last   (cell_last)
  );

endmodule

`default_nettype wire

// ----- verif/keypoint_checker.sv -----
`timescale 1ns / 1ps

module keypoint_checker import csmkt_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  reg_index_t                cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic signed [LOGIT_W-1:0] logit,
  input  logic                      frame_start,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [POINT_W-1:0]        point_x,
  input  logic [POINT_W-1:0]        point_y,
  input  logic [SCORE_W-1:0]        score,
  input  logic                      cell_last,
  output int                        mismatches,
  output int                        outstanding
);

  typedef struct packed {
    logic [POINT_W-1:0] x;
    logic [POINT_W-1:0] y;
    logic [SCORE_W-1:0] prob;
    logic               cell_end;
  } keypoint_t;

  // exp(-m/128) in Q1.16, rebuilt here from the Q0.32 recurrence
  logic [EXP_W-1:0] exp_q16 [ROM_LEN];

  logic [DIM_W-1:0]   grid_w;
  logic [DIM_W-1:0]   grid_h;
  logic [FRAC_W-1:0]  frac;
  logic [SCORE_W-1:0] thresh;

  logic [EXP_W-1:0]   bin_exp [BIN_COUNT];
  logic [SUM_W-1:0]   exp_total;
  int                 chan;
  logic [GRID_W-1:0]  col;
  logic [GRID_W-1:0]  row;

  keypoint_t expected_points [$];

  initial begin
    logic [63:0] acc;
    acc = 64'd1 << 32;
    for (int m = 0; m < ROM_LEN; m++) begin
      exp_q16[m] = EXP_W'((acc + 64'd32768) >> 16);
      acc = (acc * 64'd4261543595 + 64'h8000_0000) >> 32;
    end
    mismatches = 0;
    outstanding = 0;
  end

  function automatic int span(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    return (v > MAX_GRID_DIM) ? MAX_GRID_DIM : int'(v);
  endfunction

  task automatic flag_field(input string field, input int want, input int got);
    $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    mismatches++;
  endtask

  // Take one logit; on the dustbin, score the cell and queue its keypoints.
  task automatic absorb_logit(input logic signed [LOGIT_W-1:0] value, input logic restart);
    int               depth;
    int               m;
    int               last_hit;
    logic [EXP_W-1:0] e;
    logic [63:0]      q;
    logic [SCORE_W-1:0] prob [BIN_COUNT];
    keypoint_t        kp;
    if (restart) begin
      chan = 0;
      exp_total = '0;
      col = '0;
      row = '0;
    end
    depth = 127 - int'(value);
    m = depth << (7 - int'(frac));
    e = (m < ROM_LEN) ? exp_q16[m] : '0;
    exp_total = exp_total + SUM_W'(e);
    if (chan < BIN_COUNT) begin
      bin_exp[chan] = e;
      chan++;
    end else begin
      last_hit = -1;
      for (int b = 0; b < BIN_COUNT; b++) begin
        prob[b] = '0;
        if (exp_total != '0) begin
          q = (64'(bin_exp[b]) << 16) / 64'(exp_total);
          prob[b] = (q > 64'd65535) ? 16'hFFFF : q[SCORE_W-1:0];
        end
        if (prob[b] > thresh) last_hit = b;
      end
      for (int b = 0; b < BIN_COUNT; b++) begin
        if (prob[b] > thresh) begin
          kp.x = POINT_W'(int'(col) * CELL_SIZE + b % CELL_SIZE);
          kp.y = POINT_W'(int'(row) * CELL_SIZE + b / CELL_SIZE);
          kp.prob = prob[b];
          kp.cell_end = (b == last_hit);
          expected_points.insert(expected_points.size(), kp);
        end
      end
      chan = 0;
      exp_total = '0;
      if (int'(col) + 1 >= span(grid_w)) begin
        col = '0;
        if (int'(row) + 1 >= span(grid_h)) row = '0;
        else row = row + 1'b1;
      end else begin
        col = col + 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    keypoint_t want;
    if (rst) begin
      grid_w = 9'd80;
      grid_h = 9'd60;
      frac = 3'd4;
      thresh = 16'd983;
      exp_total = '0;
      chan = 0;
      col = '0;
      row = '0;
      expected_points.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_GRID_WIDTH:      grid_w = cfg_data[DIM_W-1:0];
          REG_GRID_HEIGHT:     grid_h = cfg_data[DIM_W-1:0];
          REG_FRAC_BITS:       frac = cfg_data[FRAC_W-1:0];
          REG_SCORE_THRESHOLD: thresh = cfg_data[SCORE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) absorb_logit(logit, frame_start);
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          $display("%0t: keypoint x=%0d y=%0d score=%0d arrived with none expected",
                   $time, point_x, point_y, score);
          mismatches++;
        end else begin
          want = expected_points.pop_front();
          if (point_x != want.x) flag_field("point_x", want.x, point_x);
          if (point_y != want.y) flag_field("point_y", want.y, point_y);
          if (score != want.prob) flag_field("score", want.prob, score);
          if (cell_last != want.cell_end) flag_field("cell_last", want.cell_end, cell_last);
        end
      end
    end
    outstanding = expected_points.size();
  end

endmodule

// ----- verif/cell_softmax_keypoint_threshold_unit_tb.sv -----
`timescale 1ns / 1ps

module cell_softmax_keypoint_threshold_unit_tb;
  import csmkt_pkg::*;

  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 1200;
  localparam int HOLD_CYCLES  = 1500;

  typedef enum int {
    CELL_RANDOM,
    CELL_FLAT,
    CELL_SPIKE,
    CELL_PEAKED,
    CELL_NARROW,
    CELL_COLD,
    CELL_DUSTBIN,
    CELL_NOISE
  } cell_kind_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  reg_index_t                cfg_index;
  logic [CFG_W-1:0]          cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [LOGIT_W-1:0] logit;
  logic                      frame_start;
  logic                      out_valid;
  logic                      out_stall;
  logic [POINT_W-1:0]        point_x;
  logic [POINT_W-1:0]        point_y;
  logic [SCORE_W-1:0]        score;
  logic                      cell_last;
  int                        mismatches;
  int                        outstanding;

  bit burst = 1'b0;
  bit squeeze = 1'b0;
  int logits_sent = 0;

  cell_softmax_keypoint_threshold_unit dut (.*);

  keypoint_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 5))
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'd256;
      3: return DIM_W'($urandom_range(257, 511));
      default: return DIM_W'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic logic [SCORE_W-1:0] pick_threshold();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return SCORE_W'($urandom);
      default: return SCORE_W'($urandom_range(200, 3000));
    endcase
  endfunction

  function automatic int shape_logit(cell_kind_t kind, int ch, int level, int spot);
    case (kind)
      CELL_FLAT:    return level;
      CELL_SPIKE:   return (ch == spot) ? 127 : -128;
      CELL_PEAKED:  return ($urandom_range(0, 9) == 0) ? int'($urandom_range(96, 127))
                                                       : int'($urandom_range(0, 88)) - 128;
      CELL_NARROW:  return level + int'($urandom_range(0, 6)) - 3;
      // at zero fraction bits all of these fall off the end of the table
      CELL_COLD:    return int'($urandom_range(0, 243)) - 128;
      CELL_DUSTBIN: return (ch == BIN_COUNT) ? 127 : int'($urandom_range(0, 100)) - 40;
      default:      return int'($urandom_range(0, 255)) - 128;
    endcase
  endfunction

  // Offer one word and hold it until taken, then maybe idle.
  task automatic send_word(input int value, input bit start);
    int gap;
    in_valid <= 1'b1;
    logit <= LOGIT_W'(value);
    frame_start <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    logits_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_cell(input cell_kind_t kind, input bit start, input int level);
    int spot;
    bit fs;
    spot = $urandom_range(0, BIN_COUNT - 1);
    burst = ($urandom_range(0, 3) == 0);
    for (int ch = 0; ch <= BIN_COUNT; ch++) begin
      fs = (ch == 0) ? start : (kind == CELL_NOISE && $urandom_range(0, 15) == 0);
      send_word(shape_logit(kind, ch, level, spot), fs);
    end
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Upper data bits are junk for the narrow registers.
  task automatic program_regs(input logic [DIM_W-1:0] gw, input logic [DIM_W-1:0] gh,
                              input logic [FRAC_W-1:0] fb, input logic [SCORE_W-1:0] thr);
    write_reg(REG_GRID_WIDTH, {7'($urandom), gw});
    write_reg(REG_GRID_HEIGHT, {7'($urandom), gh});
    write_reg(REG_FRAC_BITS, {13'($urandom), fb});
    write_reg(REG_SCORE_THRESHOLD, thr);
    cfg_write <= 1'b0;
  endtask

  // Wait for the last keypoint, then for a cell pass that may emit nothing.
  task automatic settle();
    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver: short stalls, long stalls, free stretches, and one long hold-off on request
  initial begin
    int r;
    out_stall <= 1'b0;
    repeat (6) @(posedge clk);
    forever begin
      if (squeeze) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        squeeze = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(20, 200)) @(posedge clk);
        end else if (r < 90) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(30, 150)) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int cells;
    bit start;
    cell_kind_t kind;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data <= '0;
    in_valid <= 1'b0;
    logit <= '0;
    frame_start <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // logit extremes, then restart the frame partway through a cell
    send_word(127, 1'b1);
    send_word(-128, 1'b0);
    send_word(0, 1'b0);
    send_word(-1, 1'b0);
    send_word(1, 1'b0);
    send_word(64, 1'b0);
    send_word(-64, 1'b0);
    // flat cell: every bin just above the default threshold
    send_cell(CELL_FLAT, 1'b1, 127);
    // single live bin: score saturates
    send_cell(CELL_SPIKE, 1'b0, 0);
    in_valid <= 1'b0;

    for (int p = 0; p < 5 || logits_sent < 480; p++) begin
      settle();
      start = 1'b1;
      cells = 1;
      case (p)
        0: program_regs(9'd1, 9'd1, 3'd7, 16'd0);
        1: program_regs(9'd0, 9'd0, 3'd0, 16'd0);
        2: program_regs(9'd511, 9'd256, 3'd3, 16'd983);
        3: begin
          // shrink the grid under a column beyond the new width
          program_regs(9'd1, 9'd2, 3'd5, 16'd1200);
          start = 1'b0;
          cells = 2;
          squeeze = 1'b1;
        end
        4: begin
          program_regs(9'd256, 9'd1, 3'd6, 16'hFFFF);
          start = 1'b0;
        end
        default: begin
          program_regs(pick_dim(), pick_dim(), FRAC_W'($urandom), pick_threshold());
          start = $urandom_range(0, 1);
          cells = $urandom_range(1, 2);
          if ($urandom_range(0, 5) == 0) squeeze = 1'b1;
        end
      endcase
      for (int c = 0; c < cells; c++) begin
        case (p)
          0: kind = CELL_RANDOM;
          1: kind = CELL_COLD;
          2: kind = (c == 0) ? CELL_PEAKED : CELL_NARROW;
          3: kind = (c == 0) ? CELL_DUSTBIN : CELL_RANDOM;
          4: kind = CELL_SPIKE;
          default: kind = cell_kind_t'($urandom_range(0, 7));
        endcase
        send_cell(kind, start && c == 0, int'($urandom_range(0, 200)) - 100);
      end
      in_valid <= 1'b0;
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
